>>> hdl/vdt_pkg.sv
// ----------------------------------------------------------------------------
// vdt_pkg - shared types and constants of the vertex dedup table
// Table depth, index and count widths, the stored vertex record, the store
// write port and the sequencer states.
// ----------------------------------------------------------------------------
package vdt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W   = 8;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    // one vertex, raw float bit patterns, low word first in each pair
    typedef struct packed {
        logic [63:0] pos_xy;
        logic [63:0] pos_zw;
        logic [63:0] tex_uv;
        logic [63:0] normal_xy;
        logic [63:0] normal_zw;
        logic [63:0] color_rg;
        logic [31:0] color_b;
    } t_vertex;

    // write port of the vertex store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_vertex          data;
    } t_wr_port;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_RESULT
    } t_state;

endpackage

>>> hdl/vdt_intf.sv
// ----------------------------------------------------------------------------
// vdt_intf - valid/ready channels of the vertex dedup table
// vdt_in_if carries one referenced vertex, vdt_out_if one lookup result.
// ----------------------------------------------------------------------------
interface vdt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] pos_xy;
    logic [63:0] pos_zw;
    logic [63:0] tex_uv;
    logic [63:0] normal_xy;
    logic [63:0] normal_zw;
    logic [63:0] color_rg;
    logic [31:0] color_b;

    modport source (
        output valid, pos_xy, pos_zw, tex_uv, normal_xy, normal_zw, color_rg, color_b,
        input  ready
    );
    modport sink (
        input  valid, pos_xy, pos_zw, tex_uv, normal_xy, normal_zw, color_rg, color_b,
        output ready
    );
endinterface

interface vdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] vertex_index;
    logic       appended;
    logic       table_full;

    modport source (
        output valid, vertex_index, appended, table_full,
        input  ready
    );
    modport sink (
        input  valid, vertex_index, appended, table_full,
        output ready
    );
endinterface

>>> hdl/vdt_store.sv
// ----------------------------------------------------------------------------
// vdt_store - unique vertex storage
// Single write port, single read port, read data registered. Entries hold
// no reset value; the sequencer only compares entries below the fill count.
// ----------------------------------------------------------------------------
module vdt_store (
    input  logic                    i_clk,
    input  vdt_pkg::t_wr_port       i_wr,
    input  logic [vdt_pkg::IDX_W-1:0] i_rd_addr,
    output vdt_pkg::t_vertex        o_rd_data
);
    import vdt_pkg::*;

    t_vertex r_mem [TABLE_DEPTH];
    t_vertex r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/vertex_dedup_table.sv
// ----------------------------------------------------------------------------
// vertex_dedup_table - vertex deduplication for index buffer building
// Linear search of the unique vertex table with one shared comparator;
// appends the vertex on a miss unless the table is full, and returns the entry index.
// ----------------------------------------------------------------------------
//  channel   dir  fields                                        transfer
//  i_vtx     in   pos_xy pos_zw tex_uv normal_xy normal_zw      valid & ready
//                 color_rg color_b
//  o_res     out  vertex_index appended table_full              valid & ready
//
//  a vertex is compared with the stored entries in order until a hit at entry k,
//  or on a miss past the last of the n stored entries (none when the table is
//  empty): the store's single read port feeds one entry per cycle to the
//  416-bit comparator.
//  i_vtx.ready is high only while the sequencer is idle.
//  the result sits in an output register; the next vertex may be accepted
//  while it waits, and the sequencer holds its next result until o_res frees.
//  reset clears the fill count and all control state; the store needs no sweep.
// ----------------------------------------------------------------------------
module vertex_dedup_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vdt_in_if.sink    i_vtx,
    vdt_out_if.source o_res
);
    import vdt_pkg::*;

    t_state           r_state, n_state;
    t_vertex          r_vtx, n_vtx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0] r_res_idx, n_res_idx;
    logic             r_res_app, n_res_app;
    logic             r_res_full, n_res_full;

    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic                 r_out_app;
    logic                 r_out_full;

    t_wr_port         w_wr;
    logic [IDX_W-1:0] w_rd_addr;
    t_vertex          w_rd_data;
    logic             w_hit;
    logic             w_last;
    logic             w_out_free;
    logic             w_load_out;

    // vertex store
    vdt_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // shared comparator and end-of-table check
    assign w_hit      = (w_rd_data == r_vtx);
    assign w_last     = ((CNT_W'(r_chk_idx) + CNT_W'(1)) == r_count);
    assign w_out_free = !r_out_valid || o_res.ready;

    assign i_vtx.ready = (r_state == ST_IDLE);

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtx      <= n_vtx;
        r_issue    <= n_issue;
        r_chk_idx  <= n_chk_idx;
        r_res_idx  <= n_res_idx;
        r_res_app  <= n_res_app;
        r_res_full <= n_res_full;
    end

    // sequencer: next state, store access and result
    always_comb begin
        n_state    = r_state;
        n_vtx      = r_vtx;
        n_count    = r_count;
        n_issue    = r_issue;
        n_chk_vld  = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_res_idx  = r_res_idx;
        n_res_app  = r_res_app;
        n_res_full = r_res_full;
        w_wr.en    = 1'b0;
        w_wr.addr  = r_count[IDX_W-1:0];
        w_wr.data  = r_vtx;
        w_rd_addr  = r_issue[IDX_W-1:0];
        w_load_out = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_vtx.valid) begin
                    n_vtx.pos_xy    = i_vtx.pos_xy;
                    n_vtx.pos_zw    = i_vtx.pos_zw;
                    n_vtx.tex_uv    = i_vtx.tex_uv;
                    n_vtx.normal_xy = i_vtx.normal_xy;
                    n_vtx.normal_zw = i_vtx.normal_zw;
                    n_vtx.color_rg  = i_vtx.color_rg;
                    n_vtx.color_b   = i_vtx.color_b;
                    n_issue         = '0;
                    n_state         = (r_count == '0) ? ST_MISS : ST_SCAN;
                end
            end

            ST_SCAN: begin
                // issue one read per cycle, compare the one issued last cycle
                if (r_issue < r_count) begin
                    n_issue   = r_issue + CNT_W'(1);
                    n_chk_vld = 1'b1;
                end
                n_chk_idx = r_issue[IDX_W-1:0];
                if (r_chk_vld) begin
                    if (w_hit) begin
                        n_chk_vld  = 1'b0;
                        n_res_idx  = r_chk_idx;
                        n_res_app  = 1'b0;
                        n_res_full = 1'b0;
                        n_state    = ST_RESULT;
                    end else if (w_last) begin
                        n_chk_vld = 1'b0;
                        n_state   = ST_MISS;
                    end
                end
            end

            ST_MISS: begin
                // append at the fill count unless the table is full
                if (r_count == FULL_COUNT) begin
                    n_res_idx  = '0;
                    n_res_app  = 1'b0;
                    n_res_full = 1'b1;
                end else begin
                    w_wr.en    = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    n_res_idx  = r_count[IDX_W-1:0];
                    n_res_app  = 1'b1;
                    n_res_full = 1'b0;
                end
                n_state = ST_RESULT;
            end

            ST_RESULT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_idx  <= OUT_IDX_W'(r_res_idx);
            r_out_app  <= r_res_app;
            r_out_full <= r_res_full;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.vertex_index = r_out_idx;
    assign o_res.appended     = r_out_app;
    assign o_res.table_full   = r_out_full;

endmodule

>>> hdl/vdt_checker.sv
// ----------------------------------------------------------------------------
// vdt_checker - port-level checks of the vertex dedup table
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module vdt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_index,
    input logic       i_out_appended,
    input logic       i_out_full
);

    // a search follows each input transfer, so the input is not ready after it
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready
    ) else $error("input accepted in the cycle after a transfer");

    // a result is either a hit, an append or a full table, never two
    a_flags_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_appended && i_out_full)
    ) else $error("appended and table_full both set");

    // a full-table miss reports index zero
    a_full_index_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_full) |-> (i_out_index == 8'd0)
    ) else $error("table_full result with nonzero index");

    // a stalled result stays offered
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid
    ) else $error("result dropped before transfer");

endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_vtx.valid),
    .i_in_ready     (i_vtx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_index    (o_res.vertex_index),
    .i_out_appended (o_res.appended),
    .i_out_full     (o_res.table_full)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the vertex dedup table
// Feeds referenced vertices over the input channel. Each accepted vertex
// goes through a behavioral table that predicts the index, the appended flag
// and the full flag. Every result transfer is compared, in order, with those
// predictions. The run fills the table past capacity and varies the pressure
// on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import vdt_pkg::*;

    // predicted result of one lookup
    typedef struct packed {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic                 appended;
        logic                 table_full;
    } t_lookup;

    // one vertex to send, optionally held back until all results are in
    typedef struct {
        t_vertex data;
        bit      drain_first;
    } t_send_item;

    localparam int RANDOM_ITEMS = 485;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int VTX_BITS     = $bits(t_vertex);

    logic i_clk;
    logic i_rst_n;

    vdt_in_if  vtx_if ();
    vdt_out_if res_if ();

    vertex_dedup_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_if.sink),
        .o_res   (res_if.source)
    );

    // predictor state: the unique vertices stored so far
    t_vertex     unique_vertices [TABLE_DEPTH];
    int unsigned stored_count = 0;

    t_send_item  vertex_queue [$];
    t_lookup     expected_lookups [$];

    int unsigned total_items    = 0;
    int unsigned accepted_cnt   = 0;
    int unsigned error_cnt      = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned send_idle_pct  = 9;
    int unsigned recv_stall_pct = 87;
    int unsigned hold_left      = 0;
    bit          hold_done      = 0;
    bit          vtx_taken      = 0;

    // search the stored vertices, append on a miss while there is room
    function automatic t_lookup lookup_vertex(t_vertex v);
        t_lookup r;
        r = '0;
        for (int e = 0; e < stored_count; e++) begin
            if (unique_vertices[e] == v) begin
                r.vertex_index = OUT_IDX_W'(e);
                return r;
            end
        end
        if (stored_count >= TABLE_DEPTH) begin
            r.table_full = 1'b1;
            return r;
        end
        unique_vertices[stored_count] = v;
        r.vertex_index = OUT_IDX_W'(stored_count);
        r.appended     = 1'b1;
        stored_count++;
        return r;
    endfunction

    // float word biased toward signed zeros and nan
    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FC0_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex v;
        v.pos_xy    = {random_word(), random_word()};
        v.pos_zw    = {random_word(), random_word()};
        v.tex_uv    = {random_word(), random_word()};
        v.normal_xy = {random_word(), random_word()};
        v.normal_zw = {random_word(), random_word()};
        v.color_rg  = {random_word(), random_word()};
        v.color_b   = random_word();
        return v;
    endfunction

    function automatic t_vertex flip_bit(t_vertex v, int unsigned pos);
        t_vertex r;
        r = v;
        r[pos] = ~r[pos];
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus, reset and end of run
    initial begin
        t_vertex    zero_vtx;
        t_vertex    ones_vtx;
        t_vertex    nan_vtx;
        t_vertex    v;
        t_vertex    sent [$];
        t_send_item item;
        int unsigned pick;

        i_rst_n          = 1'b0;
        vtx_if.valid     = 1'b0;
        vtx_if.pos_xy    = '0;
        vtx_if.pos_zw    = '0;
        vtx_if.tex_uv    = '0;
        vtx_if.normal_xy = '0;
        vtx_if.normal_zw = '0;
        vtx_if.color_rg  = '0;
        vtx_if.color_b   = '0;
        res_if.ready     = 1'b0;

        zero_vtx = '0;
        ones_vtx = '1;
        nan_vtx  = {13{32'h7FC0_0000}};

        // directed: extremes, signed zeros, nan, single-field differences
        item.drain_first = 1'b0;
        item.data = zero_vtx;               vertex_queue.insert(vertex_queue.size(), item);
        item.data = zero_vtx;               vertex_queue.insert(vertex_queue.size(), item);
        item.data = flip_bit(zero_vtx, 31); vertex_queue.insert(vertex_queue.size(), item);
        item.data = flip_bit(zero_vtx, 63); vertex_queue.insert(vertex_queue.size(), item);
        item.data = ones_vtx;               vertex_queue.insert(vertex_queue.size(), item);
        item.data = ones_vtx;               vertex_queue.insert(vertex_queue.size(), item);
        item.data = nan_vtx;                vertex_queue.insert(vertex_queue.size(), item);
        item.data = nan_vtx;                vertex_queue.insert(vertex_queue.size(), item);
        // top bit of each field, color_b first
        for (int k = 0; k < 7; k++) begin
            item.data = flip_bit(zero_vtx, 31 + 64 * k);
            vertex_queue.insert(vertex_queue.size(), item);
        end
        item.data = flip_bit(ones_vtx, 0);  vertex_queue.insert(vertex_queue.size(), item);
        item.drain_first = 1'b1;
        item.data = zero_vtx;               vertex_queue.insert(vertex_queue.size(), item);
        item.drain_first = 1'b0;
        item.data = ones_vtx;               vertex_queue.insert(vertex_queue.size(), item);
        foreach (vertex_queue[i]) sent.insert(sent.size(), vertex_queue[i].data);

        // random: new vertices, repeats and near misses
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                v = random_vertex();
            end else if (pick < 85) begin
                v = sent[$urandom_range(sent.size() - 1)];
            end else begin
                v = flip_bit(sent[$urandom_range(sent.size() - 1)],
                             $urandom_range(VTX_BITS - 1));
            end
            item.data        = v;
            item.drain_first = (n == 250) || (n == 450);
            vertex_queue.insert(vertex_queue.size(), item);
            sent.insert(sent.size(), v);
        end
        total_items = vertex_queue.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(accepted_cnt == total_items && expected_lookups.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // vertex driver
    always @(negedge i_clk) begin
        t_send_item nxt;
        if (!i_rst_n) begin
            vtx_if.valid <= 1'b0;
        end else if (!vtx_if.valid || vtx_taken) begin
            if (vertex_queue.size() == 0 ||
                (vertex_queue[0].drain_first && expected_lookups.size() != 0) ||
                $urandom_range(99) < send_idle_pct) begin
                vtx_if.valid <= 1'b0;
            end else begin
                nxt = vertex_queue.pop_front();
                vtx_if.valid     <= 1'b1;
                vtx_if.pos_xy    <= nxt.data.pos_xy;
                vtx_if.pos_zw    <= nxt.data.pos_zw;
                vtx_if.tex_uv    <= nxt.data.tex_uv;
                vtx_if.normal_xy <= nxt.data.normal_xy;
                vtx_if.normal_zw <= nxt.data.normal_zw;
                vtx_if.color_rg  <= nxt.data.color_rg;
                vtx_if.color_b   <= nxt.data.color_b;
            end
        end
    end

    // result receiver, with one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each vertex transfer, check each result transfer
    always @(posedge i_clk) begin
        t_lookup want;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (!i_rst_n) begin
            vtx_taken <= 1'b0;
        end else begin
            vtx_taken <= vtx_if.valid && vtx_if.ready;
            if (vtx_if.valid && vtx_if.ready) begin
                expected_lookups.insert(expected_lookups.size(),
                    lookup_vertex({vtx_if.pos_xy, vtx_if.pos_zw,
                    vtx_if.tex_uv, vtx_if.normal_xy, vtx_if.normal_zw,
                    vtx_if.color_rg, vtx_if.color_b}));
                accepted_cnt++;
                // idling phases: slow receiver, then slow sender, then full rate
                send_idle_pct  = (accepted_cnt < 200) ? 9  : (accepted_cnt < 400) ? 87 : 0;
                recv_stall_pct = (accepted_cnt < 200) ? 87 : (accepted_cnt < 400) ? 9  : 0;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_lookups.size() == 0) begin
                    $error("result transfer with no lookup pending: index %0d",
                           res_if.vertex_index);
                    error_cnt++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (res_if.vertex_index !== want.vertex_index) begin
                        $error("vertex_index: expected %0d, got %0d",
                               want.vertex_index, res_if.vertex_index);
                        error_cnt++;
                    end
                    if (res_if.appended !== want.appended) begin
                        $error("appended: expected %0d, got %0d",
                               want.appended, res_if.appended);
                        error_cnt++;
                    end
                    if (res_if.table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, res_if.table_full);
                        error_cnt++;
                    end
                end
            end
        end
    end

endmodule

>>> sim.f
hdl/vdt_pkg.sv
hdl/vdt_intf.sv
hdl/vdt_store.sv
hdl/vertex_dedup_table.sv
hdl/vdt_checker.sv
sim/testbench.sv
